// ----- hw/rtl/gtp_pkg.sv -----
// Shared types and constants for the Goertzel tone power core.
// Used by gtp_front, gtp_queue, gtp_back and goertzel_tone_power_core.
package gtp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TONE_COEFF    = 3'd0,
    CFG_WINDOW_FRAMES = 3'd1,
    CFG_FRAME_STEP    = 3'd2,
    CFG_CHANNEL_COUNT = 3'd3,
    CFG_BYTE_SAMPLES  = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register file contents
  typedef struct packed {
    logic signed [15:0] tone_coeff;
    logic [6:0]         window_frames;
    logic [1:0]         frame_step;
    logic [1:0]         channel_count;
    logic               byte_samples;
  } cfg_t;

  // Scaled sample width: both 8-bit and 16-bit modes land in 10 signed bits
  localparam int unsigned XW = 10;

  // Word passed from front to back
  typedef struct packed {
    logic                 take;  // sample enters the recurrence
    logic                 last;  // window closes after this item
    logic signed [XW-1:0] x;     // scaled sample
  } q_entry_t;

  // Queue between front and back
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QueueDepth = 1 << QPtrW;

  // Divide a small count by 1, 2 or 3 (zero acts as 1); exact below 1024
  function automatic logic [9:0] div_small(logic [9:0] v, logic [1:0] n);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    case (n)
      2'd2:    return {1'b0, v[9:1]};
      2'd3:    return {1'b0, p[19:11]};
      default: return v;
    endcase
  endfunction

endpackage

// ----- hw/rtl/gtp_front.sv -----
// Front end: accepts samples, tracks the window position and classifies items.
// Depends on gtp_pkg; feeds gtp_queue.
module gtp_front #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic signed [15:0] sample_i,
  input  gtp_pkg::cfg_t     cfg_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output gtp_pkg::q_entry_t q_entry_o
);

  localparam int unsigned WfCap  = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int unsigned CntW   = $clog2(WfCap * 3 + 1);
  localparam int unsigned CntW1  = CntW + 1;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW1-1:0] total, cnt_nxt;
  logic [1:0]       cc_eff, fs_eff;
  logic [6:0]       wf_eff, wf_cap;
  logic [9:0]       cnt_ext, frame, frame_grp, chan_rem, frame_rem;
  logic             take, last, accept;

  // Zero counts act as one; clamp the window length
  assign cc_eff = (cfg_i.channel_count == 2'd0) ? 2'd1 : cfg_i.channel_count;
  assign fs_eff = (cfg_i.frame_step == 2'd0) ? 2'd1 : cfg_i.frame_step;
  assign wf_eff = (cfg_i.window_frames == 7'd0) ? 7'd1 : cfg_i.window_frames;
  assign wf_cap = (32'(wf_eff) > MAX_WINDOW) ? 7'(MAX_WINDOW) : wf_eff;
  assign total  = CntW1'(wf_cap) * CntW1'(cc_eff);

  // Split the window position into channel and frame
  assign cnt_ext   = 10'(cnt_q);
  assign frame     = gtp_pkg::div_small(cnt_ext, cc_eff);
  assign chan_rem  = cnt_ext - 10'(frame * {8'd0, cc_eff});
  assign frame_grp = gtp_pkg::div_small(frame, fs_eff);
  assign frame_rem = frame - 10'(frame_grp * {8'd0, fs_eff});

  assign take    = (chan_rem == 10'd0) && (frame_rem == 10'd0);
  assign cnt_nxt = CntW1'(cnt_q) + CntW1'(1);
  assign last    = (cnt_nxt >= total);
  assign accept  = push && !q_full_i;

  // Forward only items that change state or close the window
  assign q_wr_o         = accept && (take || last);
  assign q_entry_o.take = take;
  assign q_entry_o.last = last;
  assign q_entry_o.x    = cfg_i.byte_samples ? {sample_i[7:0], 2'b00} : sample_i[15:6];

  // Advance the window position
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : cnt_nxt[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/gtp_queue.sv -----
// Short first-in first-out queue of classified words between front and back.
// Depends on gtp_pkg for the word type and depth.
module gtp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  gtp_pkg::q_entry_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output gtp_pkg::q_entry_t rd_data_o,
  output logic              empty_o
);

  gtp_pkg::q_entry_t             mem_q [gtp_pkg::QueueDepth];
  logic [gtp_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [gtp_pkg::QPtrW:0]       cnt_q;
  logic                          do_wr, do_rd;

  assign full_o    = (cnt_q == (gtp_pkg::QPtrW + 1)'(gtp_pkg::QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/gtp_back.sv -----
// Back end: Goertzel recurrence and window power on one shared multiplier,
// plus the one-word result register. Depends on gtp_pkg; reads gtp_queue.
module gtp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] coeff_i,
  input  logic               q_empty_i,
  input  gtp_pkg::q_entry_t  q_entry_i,
  output logic               q_rd_o,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] power_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL     = 8'b0000_0010,
    ST_UPD     = 8'b0000_0100,
    ST_MUL_END = 8'b0000_1000,
    ST_SQ2     = 8'b0001_0000,
    ST_SQ1     = 8'b0010_0000,
    ST_CROSS   = 8'b0100_0000,
    ST_FIN     = 8'b1000_0000
  } back_state_e;

  back_state_e        state_q, state_d;
  gtp_pkg::q_entry_t  ent_q;
  logic signed [31:0] z1_q, z1_d, z2_q, z2_d;
  logic signed [31:0] prod_q, t_q, acc_q, power_q;
  logic signed [31:0] mul_a, mul_b, coeff_ext, x_ext;
  logic               out_valid_q, out_valid_d;
  logic               ld_ent, ld_out;

  assign coeff_ext = {{16{coeff_i[15]}}, coeff_i};
  assign x_ext     = {{(32 - gtp_pkg::XW){ent_q.x[gtp_pkg::XW-1]}}, ent_q.x};
  assign empty     = !out_valid_q;
  assign power_o   = power_q;

  // Sequence the recurrence step and the window power
  always_comb begin
    state_d     = state_q;
    q_rd_o      = 1'b0;
    ld_ent      = 1'b0;
    ld_out      = 1'b0;
    z1_d        = z1_q;
    z2_d        = z2_q;
    out_valid_d = out_valid_q;
    mul_a       = z1_q;
    mul_b       = z1_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o  = 1'b1;
          ld_ent  = 1'b1;
          state_d = q_entry_i.take ? ST_MUL : ST_MUL_END;
        end
      end
      ST_MUL: begin
        mul_a   = coeff_ext;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        z1_d    = x_ext + (prod_q >>> 14) - z2_q;
        z2_d    = z1_q;
        state_d = ent_q.last ? ST_MUL_END : ST_IDLE;
      end
      ST_MUL_END: begin
        mul_a   = coeff_ext;
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a   = z2_q;
        mul_b   = z2_q;
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        mul_a   = t_q;
        mul_b   = z2_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || pop) begin
          ld_out      = 1'b1;
          out_valid_d = 1'b1;
          z1_d        = '0;
          z2_d        = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and recurrence values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      z1_q        <= '0;
      z2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      z1_q        <= z1_d;
      z2_q        <= z2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers: product, coefficient term, sum, result
  always_ff @(posedge clk_i) begin
    if (ld_ent) begin
      ent_q <= q_entry_i;
    end
    if (state_q != ST_FIN) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_SQ2) begin
      t_q <= prod_q >>> 14;
    end
    if (state_q == ST_SQ1) begin
      acc_q <= prod_q;
    end else if (state_q == ST_CROSS) begin
      acc_q <= acc_q + prod_q;
    end
    if (ld_out) begin
      power_q <= (acc_q - prod_q) >>> 5;
    end
  end

  // A pending result holds the window close until it is taken
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !pop) |=> (state_q == ST_FIN))
    else $error("window close did not wait for result slot");

  // Closing a window publishes a result and clears the recurrence
  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || pop))
      |=> (out_valid_q && z1_q == '0 && z2_q == '0))
    else $error("window close left stale state");

  // The recurrence moves only on an update step or a window close
  a_z1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD && state_q != ST_FIN) |=> $stable(z1_q))
    else $error("recurrence changed outside update");

  // An update step always follows its coefficient product
  a_upd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_UPD))
    else $error("update step out of order");

endmodule

// ----- hw/rtl/goertzel_tone_power_core.sv -----
// Goertzel tone power core on one shared 32x32 multiplier. Skipped samples are
// taken at one per cycle while the queue is not full. A recurrence sample gets
// a coefficient product and update; a closing window adds coefficient product,
// the squares, cross term and result load. Reset (rst_ni low, asynchronous)
// restores configuration defaults, clears window position, queue, recurrence and
// result flag. Depends on gtp_pkg, gtp_front, gtp_queue, gtp_back.
module goertzel_tone_power_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample side
  input  logic                          push,
  output logic                          full,
  input  logic signed [15:0]            sample_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            power_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gtp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gtp_pkg::CfgDataW-1:0]  cfg_data_i
);

  gtp_pkg::cfg_t     cfg_q;
  gtp_pkg::q_entry_t wr_entry, rd_entry;
  logic              q_wr, q_rd, q_full, q_empty;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_coeff    <= '0;
      cfg_q.window_frames <= 7'd20;
      cfg_q.frame_step    <= 2'd1;
      cfg_q.channel_count <= 2'd1;
      cfg_q.byte_samples  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gtp_pkg::CFG_TONE_COEFF:    cfg_q.tone_coeff    <= cfg_data_i;
        gtp_pkg::CFG_WINDOW_FRAMES: cfg_q.window_frames <= cfg_data_i[6:0];
        gtp_pkg::CFG_FRAME_STEP:    cfg_q.frame_step    <= cfg_data_i[1:0];
        gtp_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[1:0];
        gtp_pkg::CFG_BYTE_SAMPLES:  cfg_q.byte_samples  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  gtp_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .sample_i  (sample_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_entry_o (wr_entry)
  );

  gtp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (wr_entry),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (rd_entry),
    .empty_o   (q_empty)
  );

  gtp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coeff_i   (cfg_q.tone_coeff),
    .q_empty_i (q_empty),
    .q_entry_i (rd_entry),
    .q_rd_o    (q_rd),
    .pop       (pop),
    .empty     (empty),
    .power_o   (power_o)
  );

endmodule
